FILE: rtl/core/srs_pkg.sv
// Shared constants, codes, types and helpers for the selective-repeat sender.
`default_nettype none

package srs_pkg;

    // Window and sequence space.
    localparam int WINDOW_SIZE = 6;
    localparam int SEQ_SPACE   = 7;
    localparam int WINDOW_CAP  = (WINDOW_SIZE < SEQ_SPACE) ? WINDOW_SIZE : (SEQ_SPACE - 1);
    localparam int SEQ_IW      = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;

    // Field widths.
    localparam int TIMER_W = 16;
    localparam int CK_W    = 14;
    localparam int PSUM_W  = 13;
    localparam int SEQ_W   = 4;
    localparam int CNT_W   = 4;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd16;

    // Input kinds.
    localparam logic [1:0] KIND_MSG  = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // ACK status codes.
    localparam logic [2:0] ST_NOT_ACK = 3'd0;
    localparam logic [2:0] ST_NEW     = 3'd1;
    localparam logic [2:0] ST_DUP     = 3'd2;
    localparam logic [2:0] ST_OUTSIDE = 3'd3;
    localparam logic [2:0] ST_CORRUPT = 3'd4;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_SLIDE,
        S_DONE
    } t_state;

    // Commands to the retransmission timer.
    typedef struct packed {
        logic start;
        logic stop;
        logic dec;
    } t_tmr_cmd;

    // Timer status back to the sequencer.
    typedef struct packed {
        logic active;
        logic expiring;
    } t_tmr_sts;

    // Sequence number plus one, modulo the sequence space.
    function automatic logic [SEQ_IW-1:0] seq_inc(input logic [SEQ_IW-1:0] s);
        logic [SEQ_IW-1:0] r;
        if (s == SEQ_IW'(SEQ_SPACE - 1)) begin
            r = '0;
        end else begin
            r = s + SEQ_IW'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/srs_timer.sv
// Retransmission timer with load, stop and tick-down commands.
`default_nettype none

module srs_timer (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire logic [srs_pkg::TIMER_W-1:0] i_timeout,
    input  wire srs_pkg::t_tmr_cmd           i_cmd,
    output srs_pkg::t_tmr_sts                o_sts
);

    logic [srs_pkg::TIMER_W-1:0] r_remaining;
    logic [srs_pkg::TIMER_W-1:0] n_remaining;
    logic                        r_active;
    logic                        n_active;

    // Start has priority; a zero timeout behaves as one tick.
    always_comb begin
        n_remaining = r_remaining;
        n_active    = r_active;
        if (i_cmd.start) begin
            n_remaining = (i_timeout == '0) ? srs_pkg::TIMER_W'(1) : i_timeout;
            n_active    = 1'b1;
        end else if (i_cmd.stop) begin
            n_remaining = '0;
            n_active    = 1'b0;
        end else if (i_cmd.dec) begin
            n_remaining = r_remaining - srs_pkg::TIMER_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_active    <= 1'b0;
        end else begin
            r_remaining <= n_remaining;
            r_active    <= n_active;
        end
    end

    // The next tick expires the timer when one tick or less remains.
    assign o_sts.active   = r_active;
    assign o_sts.expiring = (r_remaining <= srs_pkg::TIMER_W'(1));

endmodule

`default_nettype wire

FILE: rtl/core/selective_repeat_sender_unit.sv
// Top level of the selective-repeat ARQ sender with one retransmission timer.
//
//  Channel   | Handshake                 | Payload
//  ----------+---------------------------+-------------------------------------------
//  command   | start / busy              | i_kind, i_payload_sum, i_ack_seqnum,
//            |                           | i_ack_number, i_ack_checksum
//  result    | o_done (one-cycle strobe) | o_accepted, o_ack_status, o_send_valid,
//            |                           | o_send_seqnum, o_send_checksum,
//            |                           | o_is_retransmit, o_timer_running, o_outstanding
//  config    | i_cfg_valid / o_cfg_ready | i_cfg_data (timeout_ticks)
//
// A message, a tick or a failing ACK strobes its result in the DONE state that follows
// the EXEC state after its transfer, and busy drops the cycle after.
// A new ACK adds a window slide in the SLIDE state, and when it hits
// the timed packet an oldest-unacked search in the SEARCH state first;
// an expiring tick may run that search too. Both walk one flag per cycle.
// Synchronous active-low reset clears the window, flags, timer and config to 16.
// The done strobe is high for exactly one cycle; the receiver cannot stall it.
`default_nettype none

module selective_repeat_sender_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire logic [1:0]                  i_kind,
    input  wire logic [srs_pkg::PSUM_W-1:0]  i_payload_sum,
    input  wire logic [srs_pkg::SEQ_W-1:0]   i_ack_seqnum,
    input  wire logic [srs_pkg::SEQ_W-1:0]   i_ack_number,
    input  wire logic [srs_pkg::CK_W-1:0]    i_ack_checksum,
    output logic                             o_done,
    output logic                             o_accepted,
    output logic [2:0]                       o_ack_status,
    output logic                             o_send_valid,
    output logic [srs_pkg::SEQ_W-1:0]        o_send_seqnum,
    output logic signed [srs_pkg::CK_W-1:0]  o_send_checksum,
    output logic                             o_is_retransmit,
    output logic                             o_timer_running,
    output logic [srs_pkg::CNT_W-1:0]        o_outstanding,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [srs_pkg::TIMER_W-1:0] i_cfg_data
);

    localparam int SIW = srs_pkg::SEQ_IW;
    localparam int SS  = srs_pkg::SEQ_SPACE;

    // Sequencer and window state.
    srs_pkg::t_state               r_state, n_state;
    logic [srs_pkg::TIMER_W-1:0]   r_timeout;
    logic [SIW-1:0]                r_base, n_base;
    logic [SIW-1:0]                r_next_seq, n_next_seq;
    logic [srs_pkg::CNT_W-1:0]     r_count, n_count;
    logic                          r_oldest_valid, n_oldest_valid;
    logic [SIW-1:0]                r_oldest_seq, n_oldest_seq;
    logic [SS-1:0]                 r_acked, n_acked;
    logic [SS-1:0]                 r_inwin, n_inwin;
    logic [SIW-1:0]                r_ptr, n_ptr;
    logic [srs_pkg::CNT_W-1:0]     r_walk, n_walk;
    logic                          r_then_slide, n_then_slide;

    // Latched command fields.
    logic [1:0]                    r_kind;
    logic [srs_pkg::PSUM_W-1:0]    r_psum;
    logic [srs_pkg::SEQ_W-1:0]     r_aseq;
    logic [srs_pkg::SEQ_W-1:0]     r_anum;
    logic [srs_pkg::CK_W-1:0]      r_ack_ck;

    // Result fields.
    logic                          r_accepted, n_accepted;
    logic [2:0]                    r_status, n_status;
    logic                          r_send_valid, n_send_valid;
    logic [SIW-1:0]                r_send_seq, n_send_seq;
    logic [srs_pkg::CK_W-1:0]      r_send_ck, n_send_ck;
    logic                          r_rtx, n_rtx;

    // Checksum store, one entry per sequence number, no reset.
    logic [srs_pkg::CK_W-1:0]      r_ck_mem [SS];
    logic                          ck_we;
    logic [srs_pkg::CK_W-1:0]      msg_ck;

    srs_pkg::t_tmr_cmd             tmr_cmd;
    srs_pkg::t_tmr_sts             tmr_sts;

    // ACK decode helpers.
    logic [SIW-1:0]                a_idx;
    logic                          a_in_space;
    logic [4:0]                    a_dist;
    logic                          a_sum_ok;

    srs_timer u_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_timeout (r_timeout),
        .i_cmd     (tmr_cmd),
        .o_sts     (tmr_sts)
    );

    // Shared arithmetic for the message checksum and the ACK checks.
    assign msg_ck     = srs_pkg::CK_W'(r_next_seq) + srs_pkg::CK_W'(r_psum)
                        - srs_pkg::CK_W'(1);
    assign a_sum_ok   = (srs_pkg::CK_W'(r_aseq) + srs_pkg::CK_W'(r_anum)
                        + srs_pkg::CK_W'(r_psum)) == r_ack_ck;
    assign a_idx      = r_anum[SIW-1:0];
    assign a_in_space = ({1'b0, r_anum} < 5'(SS));
    assign a_dist     = ({1'b0, r_anum} >= 5'(r_base))
                        ? ({1'b0, r_anum} - 5'(r_base))
                        : ({1'b0, r_anum} + 5'(SS) - 5'(r_base));

    // Next state and datapath control.
    always_comb begin
        n_state        = r_state;
        n_base         = r_base;
        n_next_seq     = r_next_seq;
        n_count        = r_count;
        n_oldest_valid = r_oldest_valid;
        n_oldest_seq   = r_oldest_seq;
        n_acked        = r_acked;
        n_inwin        = r_inwin;
        n_ptr          = r_ptr;
        n_walk         = r_walk;
        n_then_slide   = r_then_slide;
        n_accepted     = r_accepted;
        n_status       = r_status;
        n_send_valid   = r_send_valid;
        n_send_seq     = r_send_seq;
        n_send_ck      = r_send_ck;
        n_rtx          = r_rtx;
        ck_we          = 1'b0;
        tmr_cmd        = '0;

        case (r_state)
            srs_pkg::S_IDLE: begin
                if (start) begin
                    n_accepted   = 1'b0;
                    n_status     = srs_pkg::ST_NOT_ACK;
                    n_send_valid = 1'b0;
                    n_send_seq   = '0;
                    n_send_ck    = '0;
                    n_rtx        = 1'b0;
                    n_state      = srs_pkg::S_EXEC;
                end
            end

            srs_pkg::S_EXEC: begin
                n_state = srs_pkg::S_DONE;
                n_ptr   = r_base;
                n_walk  = r_count;
                if (r_kind == srs_pkg::KIND_MSG) begin
                    // New message enters the window when there is room.
                    if (r_count < srs_pkg::CNT_W'(srs_pkg::WINDOW_CAP)) begin
                        ck_we                = 1'b1;
                        n_acked[r_next_seq]  = 1'b0;
                        n_inwin[r_next_seq]  = 1'b1;
                        n_count              = r_count + srs_pkg::CNT_W'(1);
                        n_accepted           = 1'b1;
                        n_send_valid         = 1'b1;
                        n_send_seq           = r_next_seq;
                        n_send_ck            = msg_ck;
                        if (!r_oldest_valid) begin
                            n_oldest_valid = 1'b1;
                            n_oldest_seq   = r_next_seq;
                            tmr_cmd.start  = 1'b1;
                        end
                        n_next_seq = srs_pkg::seq_inc(r_next_seq);
                    end
                end else if (r_kind == srs_pkg::KIND_ACK) begin
                    // Classify the ACK, then mark, re-time and slide.
                    if (!a_sum_ok) begin
                        n_status = srs_pkg::ST_CORRUPT;
                    end else if (r_count == '0) begin
                        n_status = srs_pkg::ST_DUP;
                    end else if (!a_in_space || (a_dist >= {1'b0, r_count})) begin
                        n_status = srs_pkg::ST_OUTSIDE;
                    end else if (r_acked[a_idx] || !r_inwin[a_idx]) begin
                        n_status = srs_pkg::ST_DUP;
                    end else begin
                        n_status       = srs_pkg::ST_NEW;
                        n_acked[a_idx] = 1'b1;
                        if (r_oldest_valid && (a_idx == r_oldest_seq)) begin
                            tmr_cmd.stop = 1'b1;
                            n_then_slide = 1'b1;
                            n_state      = srs_pkg::S_SEARCH;
                        end else begin
                            n_state = srs_pkg::S_SLIDE;
                        end
                    end
                end else if (r_kind == srs_pkg::KIND_TICK) begin
                    // Timer tick: count down, or resend or re-time on expiry.
                    if (tmr_sts.active) begin
                        if (!tmr_sts.expiring) begin
                            tmr_cmd.dec = 1'b1;
                        end else begin
                            tmr_cmd.stop = 1'b1;
                            if (r_oldest_valid) begin
                                if (!r_acked[r_oldest_seq] && r_inwin[r_oldest_seq]) begin
                                    n_send_valid  = 1'b1;
                                    n_send_seq    = r_oldest_seq;
                                    n_send_ck     = r_ck_mem[r_oldest_seq];
                                    n_rtx         = 1'b1;
                                    tmr_cmd.start = 1'b1;
                                end else begin
                                    n_then_slide = 1'b0;
                                    n_state      = srs_pkg::S_SEARCH;
                                end
                            end
                        end
                    end
                end
            end

            srs_pkg::S_SEARCH: begin
                // Walk the window from its base for the oldest unacked packet.
                if (r_walk == '0) begin
                    n_oldest_valid = 1'b0;
                    n_oldest_seq   = '0;
                    n_state        = r_then_slide ? srs_pkg::S_SLIDE : srs_pkg::S_DONE;
                end else if (!r_acked[r_ptr] && r_inwin[r_ptr]) begin
                    n_oldest_valid = 1'b1;
                    n_oldest_seq   = r_ptr;
                    tmr_cmd.start  = 1'b1;
                    n_state        = r_then_slide ? srs_pkg::S_SLIDE : srs_pkg::S_DONE;
                end else begin
                    n_ptr  = srs_pkg::seq_inc(r_ptr);
                    n_walk = r_walk - srs_pkg::CNT_W'(1);
                end
            end

            srs_pkg::S_SLIDE: begin
                // Move the base past one acknowledged packet per cycle.
                if ((r_count != '0) && r_acked[r_base] && r_inwin[r_base]) begin
                    n_inwin[r_base] = 1'b0;
                    n_base          = srs_pkg::seq_inc(r_base);
                    n_count         = r_count - srs_pkg::CNT_W'(1);
                end else begin
                    n_state = srs_pkg::S_DONE;
                end
            end

            srs_pkg::S_DONE: begin
                n_state = srs_pkg::S_IDLE;
            end

            default: begin
                n_state = srs_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= srs_pkg::S_IDLE;
            r_timeout      <= srs_pkg::TIMEOUT_RESET;
            r_base         <= '0;
            r_next_seq     <= '0;
            r_count        <= '0;
            r_oldest_valid <= 1'b0;
            r_oldest_seq   <= '0;
            r_acked        <= '0;
            r_inwin        <= '0;
        end else begin
            r_state        <= n_state;
            r_base         <= n_base;
            r_next_seq     <= n_next_seq;
            r_count        <= n_count;
            r_oldest_valid <= n_oldest_valid;
            r_oldest_seq   <= n_oldest_seq;
            r_acked        <= n_acked;
            r_inwin        <= n_inwin;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // Payload registers: command latch, walk pointer and result fields.
    always_ff @(posedge i_clk) begin
        if ((r_state == srs_pkg::S_IDLE) && start) begin
            r_kind   <= i_kind;
            r_psum   <= i_payload_sum;
            r_aseq   <= i_ack_seqnum;
            r_anum   <= i_ack_number;
            r_ack_ck <= i_ack_checksum;
        end
        r_ptr        <= n_ptr;
        r_walk       <= n_walk;
        r_then_slide <= n_then_slide;
        r_accepted   <= n_accepted;
        r_status     <= n_status;
        r_send_valid <= n_send_valid;
        r_send_seq   <= n_send_seq;
        r_send_ck    <= n_send_ck;
        r_rtx        <= n_rtx;
    end

    // Checksum store write.
    always_ff @(posedge i_clk) begin
        if (ck_we) begin
            r_ck_mem[r_next_seq] <= msg_ck;
        end
    end

    // Ports.
    assign busy            = (r_state != srs_pkg::S_IDLE);
    assign o_done          = (r_state == srs_pkg::S_DONE);
    assign o_cfg_ready     = 1'b1;
    assign o_accepted      = r_accepted;
    assign o_ack_status    = r_status;
    assign o_send_valid    = r_send_valid;
    assign o_send_seqnum   = srs_pkg::SEQ_W'(r_send_seq);
    assign o_send_checksum = signed'(r_send_ck);
    assign o_is_retransmit = r_rtx;
    assign o_timer_running = tmr_sts.active;
    assign o_outstanding   = r_count;

`ifndef ASSERT_OFF
    // The result strobe always returns the block to idle.
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("result strobe not followed by idle");

    // The window never holds more packets than its capacity.
    a_window_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= srs_pkg::CNT_W'(srs_pkg::WINDOW_CAP))
        else $error("window count above capacity");

    // A transmission is either a new message or a resend, never both.
    a_send_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_send_valid) |-> (o_accepted != o_is_retransmit))
        else $error("transmission is neither new nor resend");

    // A started timer always means some packet is being timed.
    a_timer_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_timer_running) |-> r_oldest_valid)
        else $error("timer running with no timed packet");
`endif

endmodule

`default_nettype wire
